@@ hdl/dclk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dclk_pkg;

    // Key codes; the debounced mask must match one exactly
    localparam logic [5:0] KEY_HOUR_UP   = 6'b100001;
    localparam logic [5:0] KEY_HOUR_DOWN = 6'b100010;
    localparam logic [5:0] KEY_MIN_UP    = 6'b010001;
    localparam logic [5:0] KEY_MIN_DOWN  = 6'b010010;
    localparam logic [5:0] KEY_SEC_UP    = 6'b000101;
    localparam logic [5:0] KEY_SEC_DOWN  = 6'b000110;

    // Time limits and reset values
    localparam logic [5:0]  SEC_TOP       = 6'd59;
    localparam logic [5:0]  MIN_TOP       = 6'd59;
    localparam logic [4:0]  HOUR_TOP      = 5'd23;
    localparam logic [5:0]  SEC_RESET     = 6'd52;
    localparam logic [5:0]  MIN_RESET     = 6'd59;
    localparam logic [4:0]  HOUR_RESET    = 5'd13;
    localparam logic [15:0] TPS_RESET     = 16'd900;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] ones;
    } digits_t;

    // Split a value below 64 into tens and ones
    function automatic digits_t split_digits(input logic [5:0] v);
        digits_t d;
        logic [5:0] base;
        begin
            if (v >= 6'd60)
            begin
                d.tens = 3'd6;
            end
            else if (v >= 6'd50)
            begin
                d.tens = 3'd5;
            end
            else if (v >= 6'd40)
            begin
                d.tens = 3'd4;
            end
            else if (v >= 6'd30)
            begin
                d.tens = 3'd3;
            end
            else if (v >= 6'd20)
            begin
                d.tens = 3'd2;
            end
            else if (v >= 6'd10)
            begin
                d.tens = 3'd1;
            end
            else
            begin
                d.tens = 3'd0;
            end
            base = {d.tens, 3'b000} + {2'b00, d.tens, 1'b0};
            d.ones = 4'(v - base);
            return d;
        end
    endfunction

    // Seven-segment pattern, bit 0 = segment a; blank for non-digits
    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] s;
        begin
            case (digit)
                4'd0:    s = 7'h3F;
                4'd1:    s = 7'h06;
                4'd2:    s = 7'h5B;
                4'd3:    s = 7'h4F;
                4'd4:    s = 7'h66;
                4'd5:    s = 7'h6D;
                4'd6:    s = 7'h7D;
                4'd7:    s = 7'h07;
                4'd8:    s = 7'h7F;
                4'd9:    s = 7'h6F;
                default: s = 7'h00;
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/digital_clock_with_debounced_set_keys_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 24-hour clock with debounced set keys.
// Input channel (in_valid/in_ready/key_mask): one transaction per timer tick,
// carrying the key scan of that tick. A key action fires when the mask is
// nonzero, matches the two previous masks and differs from the third one back.
// Output channel (out_valid/out_ready): one transaction per input transaction
// with the time after the tick, a second-elapsed flag and six digit patterns.
// Config channel (cfg_valid/cfg_ready/ticks_per_second): sets the prescaler
// reload; always ready. The user must write it only while the block is idle;
// the block does not enforce this. The result register loads on the edge
// that accepts the tick. Throughput is one tick per cycle unless the receiver
// stalls; all key, prescaler and time logic sits between the state registers
// and the result register. When the receiver stalls, the result register
// holds and in_ready drops until the pending transaction is taken.
// Reset sets the time to 13:59:52, clears the prescaler and key history,
// loads 900 ticks per second and empties the result register.
module digital_clock_with_debounced_set_keys_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] ticks_per_second,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [5:0]  key_mask,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       seconds,
    output logic [5:0]       minutes,
    output logic [4:0]       hours,
    output logic             second_elapsed,
    output logic [6:0]       seg_sec_ones,
    output logic [6:0]       seg_sec_tens,
    output logic [6:0]       seg_min_ones,
    output logic [6:0]       seg_min_tens,
    output logic [6:0]       seg_hour_ones,
    output logic [6:0]       seg_hour_tens
);
    import dclk_pkg::*;

    logic [15:0] tps_reg;
    logic [15:0] tick_count_reg;
    logic [15:0] tick_count_next;
    logic [5:0]  sec_count_reg;
    logic [5:0]  sec_count_next;
    logic [5:0]  min_count_reg;
    logic [5:0]  min_count_next;
    logic [4:0]  hour_count_reg;
    logic [4:0]  hour_count_next;
    logic [5:0]  hist0_reg;
    logic [5:0]  hist1_reg;
    logic [5:0]  hist2_reg;
    logic        out_valid_reg;
    logic [5:0]  seconds_reg;
    logic [5:0]  minutes_reg;
    logic [4:0]  hours_reg;
    logic        elapsed_reg;
    logic        elapsed_next;
    logic [6:0]  seg_reg [6];

    logic        in_fire;
    logic        key_fire;
    logic [5:0]  sec_key;
    logic [5:0]  min_key;
    logic [4:0]  hour_key;
    logic [15:0] tick_inc;
    digits_t     sec_dig;
    digits_t     min_dig;
    digits_t     hour_dig;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // Debounce: stable for three scans, new against the fourth
    assign key_fire = (key_mask != 6'd0) && (key_mask == hist0_reg)
                   && (key_mask == hist1_reg) && (key_mask != hist2_reg);

    // Apply a key action to the time
    always_comb
    begin
        sec_key  = sec_count_reg;
        min_key  = min_count_reg;
        hour_key = hour_count_reg;
        if (key_fire)
        begin
            case (key_mask)
                KEY_HOUR_UP:
                    hour_key = (hour_count_reg < HOUR_TOP) ? hour_count_reg + 5'd1 : 5'd0;
                KEY_HOUR_DOWN:
                    hour_key = (hour_count_reg != 5'd0 && hour_count_reg <= HOUR_TOP)
                             ? hour_count_reg - 5'd1 : HOUR_TOP;
                KEY_MIN_UP:
                    min_key = (min_count_reg < MIN_TOP) ? min_count_reg + 6'd1 : 6'd0;
                KEY_MIN_DOWN:
                    min_key = (min_count_reg != 6'd0 && min_count_reg <= MIN_TOP)
                            ? min_count_reg - 6'd1 : MIN_TOP;
                KEY_SEC_UP:
                    sec_key = (sec_count_reg < SEC_TOP) ? sec_count_reg + 6'd1 : 6'd0;
                KEY_SEC_DOWN:
                    sec_key = (sec_count_reg != 6'd0 && sec_count_reg <= SEC_TOP)
                            ? sec_count_reg - 6'd1 : SEC_TOP;
                default:
                begin
                    sec_key  = sec_count_reg;
                end
            endcase
        end
    end

    // Advance the prescaler and, on reload, the time by one second
    assign tick_inc     = tick_count_reg + 16'd1;
    assign elapsed_next = (tick_inc >= tps_reg);

    always_comb
    begin
        tick_count_next = tick_inc;
        sec_count_next  = sec_key;
        min_count_next  = min_key;
        hour_count_next = hour_key;
        if (elapsed_next)
        begin
            tick_count_next = tick_inc - tps_reg;
            if (sec_key >= SEC_TOP)
            begin
                sec_count_next = 6'd0;
                if (min_key >= MIN_TOP)
                begin
                    min_count_next = 6'd0;
                    hour_count_next = (hour_key >= HOUR_TOP) ? 5'd0 : hour_key + 5'd1;
                end
                else
                begin
                    min_count_next = min_key + 6'd1;
                end
            end
            else
            begin
                sec_count_next = sec_key + 6'd1;
            end
        end
    end

    assign sec_dig  = split_digits(sec_count_next);
    assign min_dig  = split_digits(min_count_next);
    assign hour_dig = split_digits({1'b0, hour_count_next});

    // Hold configuration, time state and key history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg        <= TPS_RESET;
            tick_count_reg <= 16'd0;
            sec_count_reg  <= SEC_RESET;
            min_count_reg  <= MIN_RESET;
            hour_count_reg <= HOUR_RESET;
            hist0_reg      <= 6'd0;
            hist1_reg      <= 6'd0;
            hist2_reg      <= 6'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tps_reg <= ticks_per_second;
            end
            if (in_fire)
            begin
                tick_count_reg <= tick_count_next;
                sec_count_reg  <= sec_count_next;
                min_count_reg  <= min_count_next;
                hour_count_reg <= hour_count_next;
                hist2_reg      <= hist1_reg;
                hist1_reg      <= hist0_reg;
                hist0_reg      <= key_mask;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register on each accepted tick
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            seconds_reg <= sec_count_next;
            minutes_reg <= min_count_next;
            hours_reg   <= hour_count_next;
            elapsed_reg <= elapsed_next;
            seg_reg[0]  <= seg_of(sec_dig.ones);
            seg_reg[1]  <= seg_of({1'b0, sec_dig.tens});
            seg_reg[2]  <= seg_of(min_dig.ones);
            seg_reg[3]  <= seg_of({1'b0, min_dig.tens});
            seg_reg[4]  <= seg_of(hour_dig.ones);
            seg_reg[5]  <= seg_of({1'b0, hour_dig.tens});
        end
    end

    assign out_valid      = out_valid_reg;
    assign seconds        = seconds_reg;
    assign minutes        = minutes_reg;
    assign hours          = hours_reg;
    assign second_elapsed = elapsed_reg;
    assign seg_sec_ones   = seg_reg[0];
    assign seg_sec_tens   = seg_reg[1];
    assign seg_min_ones   = seg_reg[2];
    assign seg_min_tens   = seg_reg[3];
    assign seg_hour_ones  = seg_reg[4];
    assign seg_hour_tens  = seg_reg[5];

    // Time state never leaves its range
    assert property (@(posedge clk) disable iff (!rst_n)
        sec_count_reg <= SEC_TOP && min_count_reg <= MIN_TOP && hour_count_reg <= HOUR_TOP)
        else $error("time state out of range");

    // Each accepted tick leaves a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted tick produced no result");

    // A pending result mirrors the time state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (seconds_reg == sec_count_reg && minutes_reg == min_count_reg
                           && hours_reg == hour_count_reg))
        else $error("result register out of step with time state");

    // A stalled result blocks new ticks
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("tick accepted over a stalled result");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import dclk_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 6;

    typedef enum logic [1:0] {
        BIAS_MIX,
        BIAS_UP,
        BIAS_DOWN
    } set_bias_t;

    // One clock reading as the block presents it; segs[0] is the seconds units digit
    typedef struct packed {
        logic [5:0]      secs;
        logic [5:0]      mins;
        logic [4:0]      hrs;
        logic            elapsed;
        logic [5:0][6:0] segs;
    } clock_reading_t;

    // Directed row: the key scan and, where typed, the time that must follow
    typedef struct packed {
        logic [5:0] mask;
        logic       typed;
        logic [4:0] hrs;
        logic [5:0] mins;
        logic [5:0] secs;
    } key_row_t;

    localparam logic [6:0] DIGIT_SEGS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    localparam logic [5:0] UP_CODES   [3] = '{KEY_HOUR_UP, KEY_MIN_UP, KEY_SEC_UP};
    localparam logic [5:0] DOWN_CODES [3] = '{KEY_HOUR_DOWN, KEY_MIN_DOWN, KEY_SEC_DOWN};

    // Reset time is 13:59:52 with 900 ticks per second, so no second elapses here
    localparam key_row_t SET_KEY_ROWS [25] = '{
        '{6'd0,          1'b1, 5'd13, 6'd59, 6'd52},
        '{KEY_HOUR_UP,   1'b1, 5'd13, 6'd59, 6'd52},
        '{KEY_HOUR_UP,   1'b1, 5'd13, 6'd59, 6'd52},
        '{KEY_HOUR_UP,   1'b1, 5'd14, 6'd59, 6'd52},
        '{KEY_HOUR_UP,   1'b1, 5'd14, 6'd59, 6'd52},
        '{6'd0,          1'b1, 5'd14, 6'd59, 6'd52},
        '{KEY_HOUR_DOWN, 1'b1, 5'd14, 6'd59, 6'd52},
        '{KEY_HOUR_DOWN, 1'b1, 5'd14, 6'd59, 6'd52},
        '{KEY_HOUR_DOWN, 1'b1, 5'd13, 6'd59, 6'd52},
        '{KEY_MIN_UP,    1'b1, 5'd13, 6'd59, 6'd52},
        '{KEY_MIN_UP,    1'b1, 5'd13, 6'd59, 6'd52},
        '{KEY_MIN_UP,    1'b1, 5'd13, 6'd0,  6'd52},
        '{KEY_MIN_DOWN,  1'b1, 5'd13, 6'd0,  6'd52},
        '{KEY_MIN_DOWN,  1'b1, 5'd13, 6'd0,  6'd52},
        '{KEY_MIN_DOWN,  1'b1, 5'd13, 6'd59, 6'd52},
        '{KEY_SEC_UP,    1'b1, 5'd13, 6'd59, 6'd52},
        '{KEY_SEC_UP,    1'b1, 5'd13, 6'd59, 6'd52},
        '{KEY_SEC_UP,    1'b1, 5'd13, 6'd59, 6'd53},
        '{KEY_SEC_DOWN,  1'b1, 5'd13, 6'd59, 6'd53},
        '{KEY_SEC_DOWN,  1'b1, 5'd13, 6'd59, 6'd53},
        '{KEY_SEC_DOWN,  1'b1, 5'd13, 6'd59, 6'd52},
        '{6'h3F,         1'b0, 5'd0,  6'd0,  6'd0},
        '{6'h3F,         1'b0, 5'd0,  6'd0,  6'd0},
        '{6'h3F,         1'b0, 5'd0,  6'd0,  6'd0},
        '{6'd0,          1'b0, 5'd0,  6'd0,  6'd0}
    };

    // Random phases: rate, tick count, key bias; the second one runs without idling
    localparam logic [15:0] PHASE_RATE  [PHASES] = '{16'd1, 16'd300, 16'd9, 16'd0,
                                                     16'hFFFF, 16'd2};
    localparam int          PHASE_TICKS [PHASES] = '{100, 120, 100, 60, 80, 100};
    localparam set_bias_t   PHASE_BIAS  [PHASES] = '{BIAS_MIX, BIAS_DOWN, BIAS_UP,
                                                     BIAS_MIX, BIAS_DOWN, BIAS_UP};

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic [15:0] ticks_per_second = 16'd0;
    logic        in_valid         = 1'b0;
    logic        in_ready;
    logic [5:0]  key_mask         = 6'd0;
    logic        out_valid;
    logic        out_ready        = 1'b0;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic        second_elapsed;
    logic [6:0]  seg_sec_ones;
    logic [6:0]  seg_sec_tens;
    logic [6:0]  seg_min_ones;
    logic [6:0]  seg_min_tens;
    logic [6:0]  seg_hour_ones;
    logic [6:0]  seg_hour_tens;

    // Predicted clock state
    logic [15:0] rate_now   = TPS_RESET;
    logic [15:0] prescale   = 16'd0;
    logic [5:0]  secs_now   = SEC_RESET;
    logic [5:0]  mins_now   = MIN_RESET;
    logic [4:0]  hrs_now    = HOUR_RESET;
    logic [5:0]  scan_hist [3] = '{6'd0, 6'd0, 6'd0};

    clock_reading_t expected_readings [$];
    clock_reading_t want;
    clock_reading_t got;

    logic steady = 1'b0;
    int   errors = 0;
    int   mismatches = 0;
    int   ticks_sent = 0;
    int   readings_seen = 0;
    int   key_actions = 0;
    int   seconds_advanced = 0;
    int   day_wraps = 0;
    int   quiet_cycles = 0;
    string seg_names [6] = '{"seg_sec_ones", "seg_sec_tens", "seg_min_ones",
                             "seg_min_tens", "seg_hour_ones", "seg_hour_tens"};

    digital_clock_with_debounced_set_keys_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .ticks_per_second (ticks_per_second),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .key_mask         (key_mask),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .seconds          (seconds),
        .minutes          (minutes),
        .hours            (hours),
        .second_elapsed   (second_elapsed),
        .seg_sec_ones     (seg_sec_ones),
        .seg_sec_tens     (seg_sec_tens),
        .seg_min_ones     (seg_min_ones),
        .seg_min_tens     (seg_min_tens),
        .seg_hour_ones    (seg_hour_ones),
        .seg_hour_tens    (seg_hour_tens)
    );

    always #1 clk = ~clk;

    // Build a reading with its digit patterns from a time of day
    function automatic clock_reading_t make_reading(input logic [4:0] h, input logic [5:0] m,
                                                    input logic [5:0] s, input logic el);
        clock_reading_t r;
        r.secs    = s;
        r.mins    = m;
        r.hrs     = h;
        r.elapsed = el;
        r.segs[0] = DIGIT_SEGS[s % 10];
        r.segs[1] = DIGIT_SEGS[s / 10];
        r.segs[2] = DIGIT_SEGS[m % 10];
        r.segs[3] = DIGIT_SEGS[m / 10];
        r.segs[4] = DIGIT_SEGS[h % 10];
        r.segs[5] = DIGIT_SEGS[h / 10];
        return r;
    endfunction

    // Advance the predicted clock by one tick and return the reading it shows
    function automatic clock_reading_t advance_clock(input logic [5:0] mask);
        logic el;
        el = 1'b0;
        // Debounce: stable for three scans, new relative to the fourth
        if (mask != 6'd0 && mask == scan_hist[0] && mask == scan_hist[1] &&
            mask != scan_hist[2])
        begin
            if (mask inside {KEY_HOUR_UP, KEY_HOUR_DOWN, KEY_MIN_UP, KEY_MIN_DOWN,
                             KEY_SEC_UP, KEY_SEC_DOWN})
            begin
                key_actions++;
            end
            case (mask)
                KEY_HOUR_UP:   hrs_now  = (hrs_now < HOUR_TOP) ? hrs_now + 5'd1 : 5'd0;
                KEY_HOUR_DOWN: hrs_now  = (hrs_now > 5'd0 && hrs_now <= HOUR_TOP) ?
                                          hrs_now - 5'd1 : HOUR_TOP;
                KEY_MIN_UP:    mins_now = (mins_now < MIN_TOP) ? mins_now + 6'd1 : 6'd0;
                KEY_MIN_DOWN:  mins_now = (mins_now > 6'd0 && mins_now <= MIN_TOP) ?
                                          mins_now - 6'd1 : MIN_TOP;
                KEY_SEC_UP:    secs_now = (secs_now < SEC_TOP) ? secs_now + 6'd1 : 6'd0;
                KEY_SEC_DOWN:  secs_now = (secs_now > 6'd0 && secs_now <= SEC_TOP) ?
                                          secs_now - 6'd1 : SEC_TOP;
                default: ;
            endcase
        end
        scan_hist[2] = scan_hist[1];
        scan_hist[1] = scan_hist[0];
        scan_hist[0] = mask;

        // Prescaler: subtract the rate once when reached, then carry through the time
        prescale = prescale + 16'd1;
        if (prescale >= rate_now)
        begin
            prescale = prescale - rate_now;
            el = 1'b1;
            seconds_advanced++;
            if (secs_now == SEC_TOP)
            begin
                secs_now = 6'd0;
                if (mins_now == MIN_TOP)
                begin
                    mins_now = 6'd0;
                    if (hrs_now == HOUR_TOP)
                    begin
                        hrs_now = 5'd0;
                        day_wraps++;
                    end
                    else
                    begin
                        hrs_now = hrs_now + 5'd1;
                    end
                end
                else
                begin
                    mins_now = mins_now + 6'd1;
                end
            end
            else
            begin
                secs_now = secs_now + 6'd1;
            end
        end
        return make_reading(hrs_now, mins_now, secs_now, el);
    endfunction

    function automatic logic [5:0] pick_code(input set_bias_t bias);
        logic [5:0] c;
        case (bias)
            BIAS_UP:   c = UP_CODES[$urandom_range(0, 2)];
            BIAS_DOWN: c = DOWN_CODES[$urandom_range(0, 2)];
            default:   c = $urandom_range(0, 1) ? UP_CODES[$urandom_range(0, 2)] :
                                                  DOWN_CODES[$urandom_range(0, 2)];
        endcase
        return c;
    endfunction

    // Offer one tick, hold it until taken, then queue the reading it must produce
    task automatic send_tick(input logic [5:0] mask, input logic typed,
                             input clock_reading_t typed_reading);
        clock_reading_t r;
        while (!steady && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_mask <= mask;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
        r = advance_clock(mask);
        expected_readings.push_back(typed ? typed_reading : r);
    endtask

    task automatic press(input logic [5:0] mask);
        send_tick(mask, 1'b0, '0);
    endtask

    // Drop valid and hold until every queued reading has come back
    task automatic wait_for_readings();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_readings.size() != 0);
    endtask

    task automatic write_rate(input logic [15:0] rate);
        cfg_valid        <= 1'b1;
        ticks_per_second <= rate;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_now = rate;
    endtask

    // One full press of a set key: release, then three stable scans
    task automatic fire_key(input logic [5:0] code);
        press(6'd0);
        repeat (3) press(code);
    endtask

    // Key presses with random content, some bounces and some scan noise
    task automatic run_key_traffic(input int n, input set_bias_t bias);
        int         stop_at;
        int         r;
        int         hold;
        logic [5:0] code;
        logic [5:0] lead;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at)
        begin
            r    = $urandom_range(0, 99);
            code = pick_code(bias);
            lead = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(0, 63));
            if (r < 70)
            begin
                hold = $urandom_range(3, 6);
                if (lead == code)
                begin
                    lead = 6'd0;
                end
            end
            else if (r < 85)
            begin
                hold = $urandom_range(1, 2);
            end
            else
            begin
                code = 6'($urandom_range(0, 63));
                hold = $urandom_range(1, 4);
            end
            press(lead);
            repeat (hold) press(code);
            if ($urandom_range(0, 49) == 0)
            begin
                wait_for_readings();
            end
        end
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch on %s in reading %0d: expected %0d, got %0d",
                         name, readings_seen, want_v, got_v);
            end
        end
    endtask

    // Receiver: random back-pressure except in the steady stretch
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= 29);
    end

    // Compare each reading taken with the oldest one predicted
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                errors++;
                $display("reading %0d arrived with none pending", readings_seen);
            end
            else
            begin
                want = expected_readings.pop_front();
                got.secs    = seconds;
                got.mins    = minutes;
                got.hrs     = hours;
                got.elapsed = second_elapsed;
                got.segs    = {seg_hour_tens, seg_hour_ones, seg_min_tens, seg_min_ones,
                               seg_sec_tens, seg_sec_ones};
                check_field("seconds", want.secs, got.secs);
                check_field("minutes", want.mins, got.mins);
                check_field("hours", want.hrs, got.hrs);
                check_field("second_elapsed", want.elapsed, got.elapsed);
                for (int k = 0; k < 6; k++)
                begin
                    check_field(seg_names[k], want.segs[k], got.segs[k]);
                end
            end
            readings_seen++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed keys at the reset rate
        foreach (SET_KEY_ROWS[i])
        begin
            send_tick(SET_KEY_ROWS[i].mask, SET_KEY_ROWS[i].typed,
                      make_reading(SET_KEY_ROWS[i].hrs, SET_KEY_ROWS[i].mins,
                                   SET_KEY_ROWS[i].secs, 1'b0));
        end
        wait_for_readings();

        // Freeze time and set the clock to 23:59 so the next phase crosses midnight
        write_rate(16'hFFFF);
        while (hrs_now != HOUR_TOP)
        begin
            fire_key((HOUR_TOP - hrs_now <= hrs_now + 5'd1) ? KEY_HOUR_UP : KEY_HOUR_DOWN);
        end
        while (mins_now != MIN_TOP)
        begin
            fire_key((MIN_TOP - mins_now <= mins_now + 6'd1) ? KEY_MIN_UP : KEY_MIN_DOWN);
        end
        wait_for_readings();

        // Random phases across rates, including a rate dropped below the count
        for (int p = 0; p < PHASES; p++)
        begin
            write_rate(PHASE_RATE[p]);
            steady = (p == 1);
            run_key_traffic(PHASE_TICKS[p], PHASE_BIAS[p]);
            wait_for_readings();
        end
        steady = 1'b0;

        repeat (4) @(posedge clk);
        if (expected_readings.size() != 0)
        begin
            errors += expected_readings.size();
            $display("%0d readings never arrived", expected_readings.size());
        end
        $display("Run covered %0d ticks, %0d set-key actions, %0d seconds advanced",
                 ticks_sent, key_actions, seconds_advanced);
        $display("and %0d midnight rollovers over rates 900, 65535, 1, 300, 9, 0 and 2",
                 day_wraps);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
